/* sv/kbms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kbms_pkg;

   // matrix geometry
   localparam int ROW_COUNT  = 12;
   localparam int SCAN_PAIRS = 6;
   localparam int ROW_IDX_W  = 4;
   localparam int DATA_W     = 8;
   localparam int SEL_C_W    = 6;
   localparam int OP_W       = 3;
   localparam int CSR_IDX_W  = 2;

   // status bit positions on port c
   localparam int STATUS_PAL_BIT  = 6;
   localparam int STATUS_M700_BIT = 7;

   // request operations
   typedef enum logic [OP_W-1:0] {
      OP_SET_ROW   = 3'd0,
      OP_WR_SEL_A  = 3'd1,
      OP_WR_SEL_B  = 3'd2,
      OP_WR_SEL_C  = 3'd3,
      OP_RD_PORT_A = 3'd4,
      OP_RD_PORT_B = 3'd5,
      OP_RD_PORT_C = 3'd6
   } op_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODEL_500   = 2'd0,
      CSR_NTSC_TIMING = 2'd1,
      CSR_MODEL_700   = 2'd2
   } csr_idx_type;

   // one request as held in the input register
   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [ROW_IDX_W-1:0] row_index;
      logic [DATA_W-1:0]    write_value;
   } req_type;

   // configuration bits
   typedef struct packed {
      logic model_500_mode;
      logic ntsc_timing;
      logic model_700;
   } cfg_type;

   // matrix contents seen by the scan logic
   typedef struct packed {
      logic [ROW_COUNT-1:0][DATA_W-1:0] rows;
      logic [DATA_W-1:0]                sel_a;
      logic [DATA_W-1:0]                sel_b;
      logic [SEL_C_W-1:0]               sel_c;
   } scan_state_type;

   function automatic logic is_read_op(input logic [OP_W-1:0] op);
      logic r;
      r = (op == OP_RD_PORT_A) || (op == OP_RD_PORT_B) || (op == OP_RD_PORT_C);
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/keyboard_matrix_scan_ports_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------------------
// req_      | in        | req_tvalid/req_tready  | tdata: op, row_index, write_value
// rsp_      | out       | rsp_tvalid/rsp_tready  | tdata: read_data
// csr_      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// one request per cycle while the input is not stalled; a read's answer passes through
// the input register, then the result register
// row writes and latch writes take effect when the request leaves the input register
// reset clears key rows, select latches, configuration and both valid flags
// a read held behind an untaken response stalls the input; writes pass it

module keyboard_matrix_scan_ports_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // op[2:0], row_index[6:3], write_value[14:7], pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // read_data[7:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic        csr_data
);
   import kbms_pkg::*;

   req_type            s1_req_ff, s1_req_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   cfg_type            cfg_ff, cfg_in;
   logic               s1_read;
   logic               s1_advance;
   logic               req_accept;
   logic [DATA_W-1:0]  scan_data;
   scan_state_type     mstate;

   // request pipeline control
   assign s1_read    = is_read_op(s1_req_ff.op);
   assign s1_advance = s1_valid_ff && (!s1_read || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (req_accept) begin
         s1_valid_in           = 1'b1;
         s1_req_in.op          = req_tdata[2:0];
         s1_req_in.row_index   = req_tdata[6:3];
         s1_req_in.write_value = req_tdata[14:7];
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance && s1_read) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = scan_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODEL_500:   cfg_in.model_500_mode = csr_data;
            CSR_NTSC_TIMING: cfg_in.ntsc_timing    = csr_data;
            CSR_MODEL_700:   cfg_in.model_700      = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      s1_req_ff   <= s1_req_in;
      rsp_data_ff <= rsp_data_in;
   end

   kbms_rows u_rows (
      .clock (clock),
      .reset (reset),
      .exec  (s1_advance),
      .req   (s1_req_ff),
      .state (mstate)
   );

   kbms_scan u_scan (
      .state     (mstate),
      .cfg       (cfg_ff),
      .op        (s1_req_ff.op),
      .read_data (scan_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a blocked read stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_read && rsp_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("blocked read lost from input register");

   // a new response only follows a read leaving the input register
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(s1_advance && s1_read))
      else $error("response without a read request");

   // the input stalls only behind a read waiting on the output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s1_read && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without cause");

   // a non-read request never produces a response
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !s1_read && !(rsp_valid_ff && !rsp_tready)) |=> !rsp_tvalid)
      else $error("write request produced a response");

endmodule

`default_nettype wire

/* sv/kbms_rows.sv */
`timescale 1ns / 1ps
`default_nettype none

module kbms_rows (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    exec,
   input  wire kbms_pkg::req_type       req,
   output kbms_pkg::scan_state_type     state
);
   import kbms_pkg::*;

   logic [ROW_COUNT-1:0][DATA_W-1:0] rows_ff, rows_in;
   logic [DATA_W-1:0]                sel_a_ff, sel_a_in;
   logic [DATA_W-1:0]                sel_b_ff, sel_b_in;
   logic [SEL_C_W-1:0]               sel_c_ff, sel_c_in;

   // row writes, out-of-range indexes match no row
   always_comb begin
      for (int r = 0; r < ROW_COUNT; r++) begin
         rows_in[r] = rows_ff[r];
         if (exec && (req.op == OP_SET_ROW) && (req.row_index == ROW_IDX_W'(r))) begin
            rows_in[r] = req.write_value;
         end
      end
   end

   // select latch writes
   always_comb begin
      sel_a_in = sel_a_ff;
      sel_b_in = sel_b_ff;
      sel_c_in = sel_c_ff;
      if (exec) begin
         case (req.op)
            OP_WR_SEL_A: sel_a_in = req.write_value;
            OP_WR_SEL_B: sel_b_in = req.write_value;
            OP_WR_SEL_C: sel_c_in = req.write_value[SEL_C_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= '0;
         sel_a_ff <= '0;
         sel_b_ff <= '0;
         sel_c_ff <= '0;
      end else begin
         rows_ff  <= rows_in;
         sel_a_ff <= sel_a_in;
         sel_b_ff <= sel_b_in;
         sel_c_ff <= sel_c_in;
      end
   end

   assign state.rows  = rows_ff;
   assign state.sel_a = sel_a_ff;
   assign state.sel_b = sel_b_ff;
   assign state.sel_c = sel_c_ff;

endmodule

`default_nettype wire

/* sv/kbms_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module kbms_scan (
   input  wire kbms_pkg::scan_state_type        state,
   input  wire kbms_pkg::cfg_type               cfg,
   input  wire logic [kbms_pkg::OP_W-1:0]       op,
   output logic [kbms_pkg::DATA_W-1:0]          read_data
);
   import kbms_pkg::*;

   logic [SCAN_PAIRS-1:0][DATA_W-1:0] even_row;
   logic [SCAN_PAIRS-1:0][DATA_W-1:0] odd_row;
   logic [DATA_W-1:0]                 or_a;
   logic [DATA_W-1:0]                 or_b;
   logic [DATA_W-1:0]                 acc_c;

   // pick the row pairs, rows past the end read as zero
   for (genvar i = 0; i < SCAN_PAIRS; i++) begin : g_pair
      if (2*i < ROW_COUNT) begin : g_even
         assign even_row[i] = state.rows[2*i];
      end else begin : g_even_none
         assign even_row[i] = '0;
      end
      if (2*i+1 < ROW_COUNT) begin : g_odd
         assign odd_row[i] = state.rows[2*i+1];
      end else begin : g_odd_none
         assign odd_row[i] = '0;
      end
   end

   // row scans for ports a and b, select c bits are active low
   always_comb begin
      or_a = '0;
      or_b = '0;
      for (int i = 0; i < SCAN_PAIRS; i++) begin
         if (!state.sel_c[i]) begin
            or_a = or_a | even_row[i];
            or_b = or_b | odd_row[i];
         end
      end
   end

   // reverse scan for port c, plus status bits when not in model 500 mode
   always_comb begin
      acc_c = '0;
      for (int i = 0; i < SCAN_PAIRS; i++) begin
         acc_c[i] = |(even_row[i] & ~state.sel_a) | |(odd_row[i] & ~state.sel_b);
      end
      if (!cfg.model_500_mode) begin
         acc_c[STATUS_PAL_BIT]  = !cfg.ntsc_timing;
         acc_c[STATUS_M700_BIT] = !cfg.model_700;
      end
   end

   // port select, everything is active low
   always_comb begin
      unique case (op)
         OP_RD_PORT_A: read_data = ~or_a;
         OP_RD_PORT_B: read_data = ~or_b;
         OP_RD_PORT_C: read_data = ~acc_c;
         default:      read_data = '1;
      endcase
   end

endmodule

`default_nettype wire
